[sv/buffer_dependency_tracker_core_assert.svh]
// assertion macros for the buffer dependency tracker
`ifndef BUFFER_DEPENDENCY_TRACKER_CORE_ASSERT_SVH
`define BUFFER_DEPENDENCY_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdt assertion failed");

// next-cycle implication, disabled while reset is low
`define BDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdt assertion failed");

`endif

[sv/bdt_pkg.sv]
// shared types and constants of the buffer dependency tracker
package bdt_pkg;

    localparam int CNT_W       = 6;
    localparam int TASK_W      = 16;
    localparam int DEV_W       = 4;
    localparam int MAX_DEVICES = 16;

    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic       REG_ASSIGN_EN = 1'b0;
    localparam logic       REG_DEV_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TASK_W-1:0] task_id;
        logic [5:0]        buffer_id;
    } t_in;

    typedef struct packed {
        logic              kind;
        logic [TASK_W-1:0] parent_task;
        logic              device_valid;
        logic [DEV_W-1:0]  device;
        logic              overflow;
        logic              last;
    } t_out;

    typedef struct packed {
        logic              writer_valid;
        logic [TASK_W-1:0] writer_task;
        logic [CNT_W-1:0]  reader_count;
        logic              device_set;
        logic [DEV_W-1:0]  device;
    } t_meta;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_EVAL,
        S_RADDR,
        S_RDATA,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic oob;
        logic cmd_read;
        logic need_w;
        logic need_r;
        logic out_free;
        logic clr_end;
        logic cnt_zero;
        logic idx_end;
    } t_seq_stat;

    typedef struct packed {
        logic clearing;
        logic in_ready;
        logic latch_meta;
        logic emit_edge;
        logic edge_from_reader;
        logic cmp_reader;
        logic rd_check;
        logic step_idx;
        logic emit_done;
    } t_seq_ctrl;

endpackage

[sv/bdt_store.sv]
// per-buffer metadata memory and reader list memory
module bdt_store #(
    parameter int NUM_BUFFERS = 64,
    parameter int BUF_W       = 6,
    parameter int IDX_W       = 3
) (
    input  logic                          i_clk,
    input  logic                          i_meta_we,
    input  logic [BUF_W-1:0]              i_meta_waddr,
    input  bdt_pkg::t_meta                i_meta_wdata,
    input  logic [BUF_W-1:0]              i_meta_raddr,
    output bdt_pkg::t_meta                o_meta_rdata,
    input  logic                          i_rd_we,
    input  logic [BUF_W+IDX_W-1:0]        i_rd_waddr,
    input  logic [bdt_pkg::TASK_W-1:0]    i_rd_wdata,
    input  logic [BUF_W+IDX_W-1:0]        i_rd_raddr,
    output logic [bdt_pkg::TASK_W-1:0]    o_rd_rdata
);

    localparam int RD_DEPTH = NUM_BUFFERS << IDX_W;

    bdt_pkg::t_meta             r_meta_mem [NUM_BUFFERS];
    logic [bdt_pkg::TASK_W-1:0] r_rd_mem   [RD_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_meta_we) begin
            r_meta_mem[i_meta_waddr] <= i_meta_wdata;
        end
        o_meta_rdata <= r_meta_mem[i_meta_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_we) begin
            r_rd_mem[i_rd_waddr] <= i_rd_wdata;
        end
        o_rd_rdata <= r_rd_mem[i_rd_raddr];
    end

endmodule

[sv/bdt_seq.sv]
// sequencer that steps one access through lookup, reader walk and done
module bdt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdt_pkg::t_seq_stat i_stat,
    output bdt_pkg::t_seq_ctrl o_ctrl
);

    bdt_pkg::t_state r_state;
    bdt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bdt_pkg::S_CLEAR: begin
                if (i_stat.clr_end) n_state = bdt_pkg::S_IDLE;
            end
            bdt_pkg::S_IDLE: begin
                if (i_stat.accept) n_state = bdt_pkg::S_META;
            end
            bdt_pkg::S_META: begin
                n_state = i_stat.oob ? bdt_pkg::S_DONE : bdt_pkg::S_EVAL;
            end
            bdt_pkg::S_EVAL: begin
                if (!(i_stat.need_w && !i_stat.out_free)) begin
                    if (i_stat.cmd_read || i_stat.cnt_zero) begin
                        n_state = bdt_pkg::S_DONE;
                    end else begin
                        n_state = bdt_pkg::S_RADDR;
                    end
                end
            end
            bdt_pkg::S_RADDR: begin
                n_state = bdt_pkg::S_RDATA;
            end
            bdt_pkg::S_RDATA: begin
                if (!(i_stat.need_r && !i_stat.out_free)) begin
                    n_state = i_stat.idx_end ? bdt_pkg::S_DONE : bdt_pkg::S_RADDR;
                end
            end
            bdt_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = bdt_pkg::S_IDLE;
            end
            default: begin
                n_state = bdt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            bdt_pkg::S_CLEAR: begin
                o_ctrl.clearing = 1'b1;
            end
            bdt_pkg::S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            bdt_pkg::S_META: begin
                o_ctrl.latch_meta = 1'b1;
            end
            bdt_pkg::S_EVAL: begin
                o_ctrl.emit_edge = i_stat.need_w && i_stat.out_free;
            end
            bdt_pkg::S_RADDR: begin
                o_ctrl.cmp_reader = 1'b1;
            end
            bdt_pkg::S_RDATA: begin
                o_ctrl.cmp_reader       = 1'b1;
                o_ctrl.rd_check         = 1'b1;
                o_ctrl.edge_from_reader = 1'b1;
                o_ctrl.emit_edge        = i_stat.need_r && i_stat.out_free;
                o_ctrl.step_idx         = !(i_stat.need_r && !i_stat.out_free);
            end
            bdt_pkg::S_DONE: begin
                o_ctrl.emit_done = i_stat.out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

[sv/buffer_dependency_tracker_core.sv]
// top level of the buffer dependency tracker
// a read steps through the lookup, evaluate and done states, then its done item is in the
// output register; a write also walks any listed readers, one read per reader on the
// single-port reader list; an output stall can hold any emitting state, and no new item is
// taken until the access is done. reset: synchronous active low; then a clearing pass sweeps
// the whole metadata memory while no item is accepted (config writes still taken)
`include "buffer_dependency_tracker_core_assert.svh"

module buffer_dependency_tracker_core #(
    parameter int NUM_BUFFERS = 64,
    parameter int MAX_READERS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input item channel
    input  logic          i_valid,
    output logic          o_stall,
    input  bdt_pkg::t_in  i_data,
    // result item channel
    output logic          o_valid,
    input  logic          i_stall,
    output bdt_pkg::t_out o_data,
    // config port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    // buffer index and reader slot widths
    localparam int BUF_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int IDX_W = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
    localparam int CNT_W = bdt_pkg::CNT_W;
    localparam int DEV_CAP = (bdt_pkg::MAX_DEVICES < 16) ? bdt_pkg::MAX_DEVICES : 16;

    // config registers
    logic       r_assign_en;
    logic [4:0] r_dev_count;
    logic       cfg_wr;
    logic       cfg_idx;

    // item context
    logic                       r_cmd_read;
    logic [bdt_pkg::TASK_W-1:0] r_task;
    logic [BUF_W-1:0]           r_buf;
    logic                       r_oob;
    bdt_pkg::t_meta             r_meta;
    logic [CNT_W-1:0]           r_idx;
    logic [CNT_W-1:0]           n_idx_inc;
    logic [BUF_W-1:0]           r_clr;
    logic [bdt_pkg::DEV_W-1:0]  r_next_dev;

    // output register
    logic          r_out_valid;
    bdt_pkg::t_out r_out;
    bdt_pkg::t_out n_out;

    // sequencer link
    bdt_pkg::t_seq_stat stat;
    bdt_pkg::t_seq_ctrl ctrl;

    // store ports
    logic                       meta_we;
    logic [BUF_W-1:0]           meta_waddr;
    bdt_pkg::t_meta             meta_wdata;
    logic [BUF_W-1:0]           meta_raddr;
    bdt_pkg::t_meta             meta_rdata;
    logic                       rd_we;
    logic [BUF_W+IDX_W-1:0]     rd_waddr;
    logic [BUF_W+IDX_W-1:0]     rd_raddr;
    logic [bdt_pkg::TASK_W-1:0] rd_rdata;

    // datapath signals
    logic                       accept;
    logic                       out_free;
    logic [11:0]                in_buf_ext;
    logic                       in_oob;
    logic [bdt_pkg::TASK_W-1:0] cmp_operand;
    logic                       task_eq;
    logic                       self_writer;
    logic                       list_full;
    logic                       add_reader;
    logic [4:0]                 dev_lim;
    logic [bdt_pkg::DEV_W-1:0]  dev_pick;
    logic [4:0]                 dev_pick_inc;
    logic                       dev_new;
    logic [bdt_pkg::DEV_W-1:0]  dev_out;
    logic                       dvalid;

    // ---------------------------------------------------------------
    // config port: always ready, register i at byte address 4*i
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assign_en <= 1'b0;
            r_dev_count <= 5'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bdt_pkg::REG_ASSIGN_EN: r_assign_en <= pwdata[0];
                bdt_pkg::REG_DEV_COUNT: r_dev_count <= pwdata[4:0];
                default: r_assign_en <= r_assign_en;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            bdt_pkg::REG_ASSIGN_EN: prdata = {31'd0, r_assign_en};
            bdt_pkg::REG_DEV_COUNT: prdata = {27'd0, r_dev_count};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshakes: input taken only in idle, output register frees when
    // empty or taken this cycle
    // ---------------------------------------------------------------
    assign o_stall  = !ctrl.in_ready;
    assign accept   = i_valid && ctrl.in_ready;
    assign out_free = !r_out_valid || !i_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // buffer ids past the configured count only produce a bare done item
    assign in_buf_ext = 12'(i_data.buffer_id);
    assign in_oob     = int'(i_data.buffer_id) >= NUM_BUFFERS;

    // ---------------------------------------------------------------
    // shared task compare: writer during lookup and done, reader entry
    // during the list walk
    // ---------------------------------------------------------------
    assign cmp_operand = ctrl.cmp_reader ? rd_rdata : r_meta.writer_task;
    assign task_eq     = (cmp_operand == r_task);

    assign self_writer = r_meta.writer_valid && task_eq;
    assign list_full   = (r_meta.reader_count >= CNT_W'(MAX_READERS));
    assign add_reader  = r_cmd_read && !r_oob && !self_writer && !list_full;

    assign n_idx_inc = r_idx + CNT_W'(1);

    always_comb begin
        stat          = '0;
        stat.accept   = accept;
        stat.oob      = r_oob;
        stat.cmd_read = r_cmd_read;
        // writer edge: reads always, writes only when no readers are listed
        stat.need_w   = r_meta.writer_valid && !task_eq
                        && (r_cmd_read || (r_meta.reader_count == '0));
        stat.need_r   = !task_eq;
        stat.out_free = out_free;
        stat.clr_end  = (r_clr == BUF_W'(NUM_BUFFERS - 1));
        stat.cnt_zero = (r_meta.reader_count == '0);
        stat.idx_end  = (n_idx_inc == r_meta.reader_count);
    end

    bdt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // ---------------------------------------------------------------
    // item context registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd_read <= (i_data.cmd == bdt_pkg::CMD_READ);
            r_task     <= i_data.task_id;
            r_buf      <= in_buf_ext[BUF_W-1:0];
            r_oob      <= in_oob;
        end
        if (ctrl.latch_meta) begin
            r_meta <= meta_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (ctrl.latch_meta) begin
            r_idx <= '0;
        end else if (ctrl.step_idx) begin
            r_idx <= n_idx_inc;
        end
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (ctrl.clearing) begin
            r_clr <= r_clr + BUF_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // round-robin device pick; a lowered count resets a stale pointer
    // ---------------------------------------------------------------
    always_comb begin
        if (r_dev_count == 5'd0) begin
            dev_lim = 5'd1;
        end else if (r_dev_count > 5'(DEV_CAP)) begin
            dev_lim = 5'(DEV_CAP);
        end else begin
            dev_lim = r_dev_count;
        end
    end

    assign dev_pick     = ({1'b0, r_next_dev} < dev_lim) ? r_next_dev : '0;
    assign dev_pick_inc = {1'b0, dev_pick} + 5'd1;
    assign dvalid       = !r_cmd_read && !r_oob && r_assign_en;
    assign dev_new      = dvalid && !r_meta.device_set;
    assign dev_out      = dev_new ? dev_pick : r_meta.device;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_dev <= '0;
        end else if (ctrl.emit_done && dev_new) begin
            r_next_dev <= (dev_pick_inc >= dev_lim) ? '0 : dev_pick_inc[3:0];
        end
    end

    // ---------------------------------------------------------------
    // memory ports
    // ---------------------------------------------------------------
    assign meta_raddr = ctrl.in_ready ? in_buf_ext[BUF_W-1:0] : r_buf;
    assign meta_we    = ctrl.clearing || (ctrl.emit_done && !r_oob);
    assign meta_waddr = ctrl.clearing ? r_clr : r_buf;

    always_comb begin
        meta_wdata = r_meta;
        if (ctrl.clearing) begin
            meta_wdata = '0;
        end else if (r_cmd_read) begin
            if (add_reader) begin
                meta_wdata.reader_count = r_meta.reader_count + CNT_W'(1);
            end
        end else begin
            // write: take over as writer, drop the reader list
            meta_wdata.writer_valid = 1'b1;
            meta_wdata.writer_task  = r_task;
            meta_wdata.reader_count = '0;
            if (dev_new) begin
                meta_wdata.device_set = 1'b1;
                meta_wdata.device     = dev_pick;
            end
        end
    end

    assign rd_we    = ctrl.emit_done && add_reader;
    assign rd_waddr = {r_buf, r_meta.reader_count[IDX_W-1:0]};
    assign rd_raddr = {r_buf, r_idx[IDX_W-1:0]};

    bdt_store #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .BUF_W       (BUF_W),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_meta_we    (meta_we),
        .i_meta_waddr (meta_waddr),
        .i_meta_wdata (meta_wdata),
        .i_meta_raddr (meta_raddr),
        .o_meta_rdata (meta_rdata),
        .i_rd_we      (rd_we),
        .i_rd_waddr   (rd_waddr),
        .i_rd_wdata   (r_task),
        .i_rd_raddr   (rd_raddr),
        .o_rd_rdata   (rd_rdata)
    );

    // ---------------------------------------------------------------
    // result item build and output register
    // ---------------------------------------------------------------
    always_comb begin
        n_out = '0;
        if (ctrl.emit_edge) begin
            n_out.parent_task = ctrl.edge_from_reader ? rd_rdata : r_meta.writer_task;
        end else begin
            n_out.kind         = 1'b1;
            n_out.last         = 1'b1;
            n_out.device_valid = dvalid;
            n_out.device       = dvalid ? dev_out : '0;
            n_out.overflow     = r_cmd_read && !r_oob && !self_writer && list_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit_edge || ctrl.emit_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit_edge || ctrl.emit_done) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // an accepted item goes straight to the metadata lookup
    `BDT_ASSERT_NXT(a_accept_lookup, i_clk, i_rst_n, accept, ctrl.latch_meta)
    // the reader walk never runs past the listed readers
    `BDT_ASSERT_IMP(a_walk_in_range, i_clk, i_rst_n, ctrl.rd_check,
        (r_idx < r_meta.reader_count) && !r_cmd_read)
    // overflow only ever rides on the done item of a read
    `BDT_ASSERT_IMP(a_ovf_on_done, i_clk, i_rst_n, o_valid && o_data.overflow,
        o_data.kind && !o_data.device_valid)

endmodule

[sim/buffer_dependency_tracker_core_test.sv]
// self-checking testbench of the buffer dependency tracker: directed and random accesses
`timescale 1ns / 1ps

module buffer_dependency_tracker_core_test;

    localparam int NUM_BUF     = 64;
    localparam int MAX_RD      = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 40;    // outlasts the longest write walk, through all MAX_RD readers
    localparam int GAP_PCT     = 15;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 55;

    // access kinds beyond the package's read code
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RDWR  = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;   // behaves as a write

    // result kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // dut signals, inputs known from time zero
    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    bdt_pkg::t_in  i_data  = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    bdt_pkg::t_out o_data;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [2:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // stimulus and scoreboard storage
    bdt_pkg::t_in  pending_q[$];     // accesses waiting for the driver
    bdt_pkg::t_out dep_results_q[$]; // edges and done items still owed by the block
    int   n_errors  = 0;
    int   cycle_cnt = 0;
    logic no_gaps   = 1'b0; // set for one whole phase: no idling on either side

    // predictor copy of the configuration
    logic       cfg_assign_en = 1'b0;
    logic [4:0] cfg_dev_count = 5'd1;

    // predictor copy of the per-buffer tracking state
    logic        wr_valid  [NUM_BUF] = '{default: 1'b0};
    logic [15:0] wr_task   [NUM_BUF];
    int          rd_cnt    [NUM_BUF] = '{default: 0};
    logic [15:0] rd_list   [NUM_BUF][MAX_RD];
    logic        dev_known [NUM_BUF] = '{default: 1'b0};
    logic [3:0]  dev_of    [NUM_BUF];
    int          rr_next = 0;

    // random pools so that accesses pile up on a few buffers and tasks
    logic [15:0] task_pool [16];
    logic [5:0]  buf_pool  [8];

    buffer_dependency_tracker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // an edge result toward one parent task
    function automatic void edge_to(logic [15:0] parent);
        bdt_pkg::t_out e;
        e             = '0;
        e.kind        = KIND_EDGE;
        e.parent_task = parent;
        dep_results_q.insert(dep_results_q.size(), e);
    endfunction

    // expected results of one accepted access, updates the tracking copy
    function automatic void track_access(bdt_pkg::t_in acc);
        bdt_pkg::t_out done;
        logic [5:0]    b;
        logic [15:0]   tid;
        logic          self_wr;
        int            lim;
        int            d;
        b    = acc.buffer_id;
        tid  = acc.task_id;
        done = '0;
        if (acc.cmd == bdt_pkg::CMD_READ) begin
            // the current writer reading its own buffer is neither an edge nor a reader
            self_wr = wr_valid[b] && (wr_task[b] == tid);
            if (wr_valid[b] && !self_wr)
                edge_to(wr_task[b]);
            if (!self_wr) begin
                if (rd_cnt[b] < MAX_RD) begin
                    rd_list[b][rd_cnt[b]] = tid;
                    rd_cnt[b]++;
                end else begin
                    done.overflow = 1'b1;   // list full, reader dropped
                end
            end
        end else begin
            // write, read-write and the spare code: war edges, else waw edge
            if (rd_cnt[b] == 0) begin
                if (wr_valid[b] && (wr_task[b] != tid))
                    edge_to(wr_task[b]);
            end else begin
                for (int i = 0; i < rd_cnt[b]; i++) begin
                    if (rd_list[b][i] != tid)
                        edge_to(rd_list[b][i]);
                end
                rd_cnt[b] = 0;
            end
            if (cfg_assign_en) begin
                if (!dev_known[b]) begin
                    // zero counts as one, counts above 16 clamp to 16
                    lim = (cfg_dev_count == 0) ? 1 : (cfg_dev_count > 16) ? 16 : cfg_dev_count;
                    // a pointer left beyond a lowered count restarts at device 0
                    d = (rr_next < lim) ? rr_next : 0;
                    dev_of[b]    = d[3:0];
                    dev_known[b] = 1'b1;
                    rr_next      = (d + 1 >= lim) ? 0 : d + 1;
                end
                done.device_valid = 1'b1;
                done.device       = dev_of[b];
            end
            wr_task[b]  = tid;
            wr_valid[b] = 1'b1;
        end
        done.kind = KIND_DONE;
        done.last = 1'b1;
        dep_results_q.insert(dep_results_q.size(), done);
    endfunction

    task automatic queue_access(logic [1:0] cmd, logic [15:0] tid, logic [5:0] bid);
        bdt_pkg::t_in acc;
        acc.cmd       = cmd;
        acc.task_id   = tid;
        acc.buffer_id = bid;
        pending_q.insert(pending_q.size(), acc);
    endtask

    // apb write: setup then access, register taken at the access edge
    task automatic reg_write(logic idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == bdt_pkg::REG_ASSIGN_EN)
            cfg_assign_en = value[0];
        else
            cfg_dev_count = value[4:0];
    endtask

    // block drained: nothing queued, nothing in flight, then let the walk settle
    task automatic wait_drained();
        while (pending_q.size() != 0 || dep_results_q.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            n_errors++;
        end
    endtask

    // driver: holds an item until taken, predicts at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                track_access(i_data);
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0 &&
                    (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
                    i_data  <= pending_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (dep_results_q.size() == 0) begin
                    $error("unexpected result: kind %0d parent %0h", o_data.kind,
                           o_data.parent_task);
                    n_errors++;
                end else begin
                    bdt_pkg::t_out want;
                    want = dep_results_q.pop_front();
                    check_field("kind",         want.kind,         o_data.kind);
                    check_field("parent_task",  want.parent_task,  o_data.parent_task);
                    check_field("device_valid", want.device_valid, o_data.device_valid);
                    check_field("device",       want.device,       o_data.device);
                    check_field("overflow",     want.overflow,     o_data.overflow);
                    check_field("last",         want.last,         o_data.last);
                end
            end
            i_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // random phase settings: assignment enable and device count
    logic       phase_en  [RAND_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    logic [4:0] phase_cnt [RAND_PHASES] = '{5'd1, 5'd16, 5'd5, 5'd31, 5'd0, 5'd2, 5'd7};

    initial begin
        int          n_items;
        int          n_rd;
        logic [5:0]  bid;
        logic [15:0] wtid;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset configuration (no device assignment)
        queue_access(bdt_pkg::CMD_READ, 16'h0000, 6'd0);   // read with no writer yet
        queue_access(CMD_WRITE, 16'hFFFF, 6'd0);   // war edge to the reader
        queue_access(bdt_pkg::CMD_READ, 16'hFFFF, 6'd0);   // writer reads its own buffer
        queue_access(CMD_RDWR,  16'hFFFF, 6'd0);   // same writer again, no edge
        queue_access(CMD_RSVD,  16'h0005, 6'd0);   // spare code acts as a write
        queue_access(CMD_WRITE, 16'd100,  6'd63);
        for (int i = 1; i <= 9; i++)               // ninth reader overflows
            queue_access(bdt_pkg::CMD_READ, i[15:0], 6'd63);
        queue_access(CMD_WRITE, 16'd3, 6'd63);     // edges to all readers but itself
        queue_access(CMD_WRITE, 16'd3, 6'd63);     // repeated writer, no edge
        wait_drained();

        // device count zero behaves as one
        reg_write(bdt_pkg::REG_ASSIGN_EN, 32'd1);
        reg_write(bdt_pkg::REG_DEV_COUNT, 32'd0);
        queue_access(CMD_WRITE, 16'd7, 6'd1);
        queue_access(CMD_WRITE, 16'd8, 6'd2);
        wait_drained();

        // oversized count clamps to sixteen
        reg_write(bdt_pkg::REG_DEV_COUNT, 32'd31);
        for (int i = 3; i <= 7; i++)
            queue_access(CMD_RDWR, 16'd20 + i[15:0], i[5:0]);
        wait_drained();

        // lowered count leaves a stale pointer, then a buffer reuses its device
        reg_write(bdt_pkg::REG_DEV_COUNT, 32'd3);
        queue_access(CMD_WRITE, 16'd40, 6'd8);
        queue_access(CMD_WRITE, 16'd41, 6'd3);
        wait_drained();

        // random phases, each under its own configuration
        for (int p = 0; p < RAND_PHASES; p++) begin
            reg_write(bdt_pkg::REG_ASSIGN_EN, {31'd0, phase_en[p]});
            reg_write(bdt_pkg::REG_DEV_COUNT, {27'd0, phase_cnt[p]});
            no_gaps = (p == 1);
            foreach (task_pool[i]) task_pool[i] = 16'($urandom_range(16'hFFFF));
            foreach (buf_pool[i])  buf_pool[i]  = 6'($urandom_range(NUM_BUF - 1));
            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    // well-formed chain: a write, a run of readers, sometimes past full
                    bid  = buf_pool[3'($urandom_range(7))];
                    wtid = task_pool[4'($urandom_range(15))];
                    queue_access(2'($urandom_range(CMD_WRITE, CMD_RSVD)), wtid, bid);
                    n_rd = $urandom_range(10);
                    for (int r = 0; r < n_rd; r++)
                        queue_access(bdt_pkg::CMD_READ,
                                     task_pool[4'($urandom_range(15))], bid);
                    n_items += 1 + n_rd;
                end else begin
                    // noise over the whole field ranges
                    queue_access(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                                 6'($urandom_range(NUM_BUF - 1)));
                    n_items++;
                end
            end
            wait_drained();
            no_gaps = 1'b0;
        end

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/bdt_pkg.sv
sv/bdt_store.sv
sv/bdt_seq.sv
sv/buffer_dependency_tracker_core.sv
sim/buffer_dependency_tracker_core_test.sv
